[rtl/mphash_pkg.sv]
// ----------------------------------------------------------------------------
// mphash_pkg
// Shared types, constants and the character map of the polynomial string hash.
// ----------------------------------------------------------------------------
package mphash_pkg;

  localparam int unsigned DATA_W   = 32;               // modulus / hash width
  localparam int unsigned MULT_W   = 16;               // final multiplier width
  localparam int unsigned CODE_W   = 6;                // character code width
  localparam int unsigned ACC_W    = 38;               // v*53 + code
  localparam int unsigned DIV_W    = DATA_W + MULT_W;  // widest dividend
  localparam int unsigned CNT_W    = 6;                // holds DIV_W
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CODE_W-1:0] HASH_RADIX = CODE_W'(1 + 2 * 26);
  localparam logic [DATA_W-1:0] MODULUS_RESET    = DATA_W'(31);
  localparam logic [MULT_W-1:0] MULTIPLIER_RESET = MULT_W'(13);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = CFG_IDX_W'(1);

  localparam logic [CNT_W-1:0] STEP_BITS  = CNT_W'(ACC_W);
  localparam logic [CNT_W-1:0] FINAL_BITS = CNT_W'(DIV_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RED_STEP,
    ST_MUL,
    ST_RED_FIN
  } state_t;

  // request to the remainder unit
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] bits;   // dividend bits to consume, MSB aligned
  } rem_req_t;

  typedef struct packed {
    logic busy;
  } rem_stat_t;

  typedef struct packed {
    logic              bad;
    logic [CODE_W-1:0] code;
  } char_map_t;

  // space -> 0, a..z -> 1..26, A..Z -> 27..52, anything else flagged as code 0
  function automatic char_map_t map_char(input logic [7:0] ch);
    char_map_t m;
    m.bad  = 1'b0;
    m.code = '0;
    if (ch == CH_SPACE) begin
      m.code = '0;
    end else if (ch inside {[CH_LO_A:CH_LO_Z]}) begin
      m.code = CODE_W'(ch - CH_LO_A) + CODE_W'(1);
    end else if (ch inside {[CH_UP_A:CH_UP_Z]}) begin
      m.code = CODE_W'(ch - CH_UP_A) + CODE_W'(27);
    end else begin
      m.bad = 1'b1;
    end
    return m;
  endfunction

endpackage

[rtl/modular_polynomial_string_hash.sv]
// ----------------------------------------------------------------------------
// modular_polynomial_string_hash
// Horner string hash v = (v*53 + code) mod M, result (W*v) mod M on last char.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------
//  in_      | input     | in_valid/in_stall  | char_code[7:0], last_char
//  out_     | output    | out_valid/out_stall| hash_value[31:0], bad_character
//  cfg_     | input     | cfg_valid/cfg_ready| cfg_index[7:0], cfg_data[31:0]
//
//  A character is loaded, reduced by the bit-serial remainder unit over 38
//  dividend bits and written back. A last character then adds the final W*v
//  reduction (48 dividend bits).
//  Reset (rst_n low, synchronous) sets M=31, W=13 and clears the running value.
//  A pending result in the output register does not block new characters; a
//  last character waits before its writeback until the register is free.
//  Config writes are taken only while idle.
// ----------------------------------------------------------------------------
module modular_polynomial_string_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value,
  output logic        out_bad_character,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [mphash_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import mphash_pkg::*;

  state_t            state_r, state_nxt;
  logic [DATA_W-1:0] modulus_r, modulus_nxt;
  logic [MULT_W-1:0] mult_r, mult_nxt;
  logic [DATA_W-1:0] v_r, v_nxt;
  logic              err_r, err_nxt;
  logic              last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_hash_r, out_hash_nxt;
  logic              out_bad_r, out_bad_nxt;

  rem_req_t          rem_req;
  rem_stat_t         rem_stat;
  logic [DIV_W-1:0]  rem_dividend;
  logic [DATA_W-1:0] rem_result;

  char_map_t         cmap;
  logic [ACC_W-1:0]  acc;
  logic              in_acc;
  logic              out_free;

  assign cmap     = map_char(in_char_code);
  assign acc      = {6'b0, v_r} * ACC_W'(HASH_RADIX) + ACC_W'(cmap.code);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  mphash_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (rem_req),
    .dividend  (rem_dividend),
    .modulus   (modulus_r),
    .stat      (rem_stat),
    .remainder (rem_result)
  );

  always_comb begin
    state_nxt     = state_r;
    modulus_nxt   = modulus_r;
    mult_nxt      = mult_r;
    v_nxt         = v_r;
    err_nxt       = err_r;
    last_nxt      = last_r;
    out_hash_nxt  = out_hash_r;
    out_bad_nxt   = out_bad_r;
    out_valid_nxt = out_valid_r && out_stall;
    rem_req.start = 1'b0;
    rem_req.bits  = STEP_BITS;
    rem_dividend  = {acc, {(DIV_W-ACC_W){1'b0}}};
    in_stall      = 1'b1;
    cfg_ready     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cfg_ready = 1'b1;
        if (cfg_valid) begin
          if (cfg_index == CFG_MODULUS) begin
            modulus_nxt = cfg_data;
          end else if (cfg_index == CFG_MULTIPLIER) begin
            mult_nxt = cfg_data[MULT_W-1:0];
          end
        end
        if (in_valid) begin
          rem_req.start = 1'b1;
          err_nxt       = err_r | cmap.bad;
          last_nxt      = in_last_char;
          state_nxt     = ST_RED_STEP;
        end
      end
      ST_RED_STEP: begin
        if (!rem_stat.busy) begin
          v_nxt     = rem_result;
          state_nxt = last_r ? ST_MUL : ST_IDLE;
        end
      end
      ST_MUL: begin
        rem_req.start = 1'b1;
        rem_req.bits  = FINAL_BITS;
        rem_dividend  = {{DATA_W{1'b0}}, mult_r} * {{MULT_W{1'b0}}, v_r};
        state_nxt     = ST_RED_FIN;
      end
      ST_RED_FIN: begin
        if (!rem_stat.busy && out_free) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = rem_result;
          out_bad_nxt   = err_r;
          v_nxt         = '0;
          err_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      modulus_r   <= MODULUS_RESET;
      mult_r      <= MULTIPLIER_RESET;
      v_r         <= '0;
      err_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      modulus_r   <= modulus_nxt;
      mult_r      <= mult_nxt;
      v_r         <= v_nxt;
      err_r       <= err_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hash_r <= out_hash_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_hash_value    = out_hash_r;
  assign out_bad_character = out_bad_r;

  // the remainder unit is never restarted while still running
  a_idle_rem_free: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !rem_stat.busy)
    else $error("input taken while remainder unit busy");

  // a result appears only out of the final reduction
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_RED_FIN))
    else $error("result without final reduction");

  // an accepted character always starts a step reduction
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_RED_STEP) && rem_stat.busy)
    else $error("accepted character did not start reduction");

  // the running value is cleared when a result is written
  a_clear_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RED_FIN) && (state_nxt == ST_IDLE) |=> (v_r == '0) && !err_r)
    else $error("running value not cleared after result");

endmodule

[rtl/mphash_rem.sv]
// ----------------------------------------------------------------------------
// mphash_rem
// Bit-serial restoring remainder: one dividend bit per cycle against M.
// ----------------------------------------------------------------------------
module mphash_rem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mphash_pkg::rem_req_t       req,
  input  logic [mphash_pkg::DIV_W-1:0]  dividend,
  input  logic [mphash_pkg::DATA_W-1:0] modulus,
  output mphash_pkg::rem_stat_t      stat,
  output logic [mphash_pkg::DATA_W-1:0] remainder
);
  import mphash_pkg::*;

  logic [DIV_W-1:0]  x_r, x_nxt;
  logic [DATA_W-1:0] r_r, r_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [DATA_W:0]   sh;
  logic              sub;

  // modulus of zero never subtracts, leaving the low 32 bits
  assign sh  = {r_r, x_r[DIV_W-1]};
  assign sub = (modulus != '0) && (sh >= {1'b0, modulus});

  always_comb begin
    x_nxt    = x_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (req.start) begin
      x_nxt    = dividend;
      r_nxt    = '0;
      cnt_nxt  = req.bits;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt   = {x_r[DIV_W-2:0], 1'b0};
      r_nxt   = sub ? DATA_W'(sh - {1'b0, modulus}) : sh[DATA_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    r_r <= r_nxt;
  end

  assign stat.busy = busy_r;
  assign remainder = r_r;

endmodule

[bench/hash_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hash_checker
// Watches the character, result and register channels of the string hash,
// keeps its own Horner accumulator and compares every hash that comes out.
// ----------------------------------------------------------------------------
module hash_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [7:0]                       in_char_code,
  input  logic                             in_last_char,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [31:0]                      out_hash_value,
  input  logic                             out_bad_character,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [mphash_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data,
  output int                               mismatches,
  output int                               hashes_pending
);
  import mphash_pkg::*;

  localparam int EXP_DEPTH = 16;

  typedef struct packed {
    logic [31:0] hash;
    logic        bad;
  } string_hash_t;

  // ring of expected results, indexed by running read and write counts
  string_hash_t expected_hashes [0:EXP_DEPTH-1];
  string_hash_t want;
  int           head_cnt = 0;
  int           tail_cnt = 0;

  logic [31:0] modulus_q    = MODULUS_RESET;
  logic [15:0] multiplier_q = MULTIPLIER_RESET;
  logic [31:0] horner_acc   = '0;
  logic        error_flag   = 1'b0;
  logic [6:0]  lookup;
  int          mismatch_cnt = 0;

  initial begin
    mismatches     = 0;
    hashes_pending = 0;
  end

  // a zero modulus stands for 2^32
  function automatic logic [31:0] mod_reduce(input logic [63:0] x, input logic [31:0] m);
    if (m == '0) return x[31:0];
    return 32'(x % {32'd0, m});
  endfunction

  // {bad, code}: space 0, a..z 1..26, A..Z 27..52, anything else bad with code 0
  function automatic logic [6:0] letter_code(input logic [7:0] ch);
    if (ch == CH_SPACE) return 7'd0;
    if (ch >= CH_LO_A && ch <= CH_LO_Z) return {1'b0, 6'(ch - CH_LO_A + 8'd1)};
    if (ch >= CH_UP_A && ch <= CH_UP_Z) return {1'b0, 6'(ch - CH_UP_A + 8'd27)};
    return {1'b1, 6'd0};
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      modulus_q    = MODULUS_RESET;
      multiplier_q = MULTIPLIER_RESET;
      horner_acc   = '0;
      error_flag   = 1'b0;
      head_cnt     = 0;
      tail_cnt     = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tail_cnt == head_cnt) begin
          $error("unexpected hash result: hash_value %0h bad_character %0b",
                 out_hash_value, out_bad_character);
          mismatch_cnt++;
        end else begin
          want = expected_hashes[4'(head_cnt)];
          head_cnt++;
          if (out_hash_value !== want.hash) begin
            $error("hash_value: expected %0h, actual %0h", want.hash, out_hash_value);
            mismatch_cnt++;
          end
          if (out_bad_character !== want.bad) begin
            $error("bad_character: expected %0b, actual %0b", want.bad, out_bad_character);
            mismatch_cnt++;
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODULUS: begin
            modulus_q = cfg_data;
          end
          CFG_MULTIPLIER: begin
            multiplier_q = cfg_data[15:0];
          end
          default: begin
          end
        endcase
      end

      if (in_valid && !in_stall) begin
        lookup     = letter_code(in_char_code);
        error_flag = error_flag | lookup[6];
        horner_acc = mod_reduce({32'd0, horner_acc} * 64'(HASH_RADIX) + 64'(lookup[5:0]),
                                modulus_q);
        if (in_last_char) begin
          want.hash = mod_reduce(64'(multiplier_q) * 64'(horner_acc), modulus_q);
          want.bad  = error_flag;
          if (tail_cnt - head_cnt == EXP_DEPTH) begin
            $error("too many hash results outstanding");
            mismatch_cnt++;
          end else begin
            expected_hashes[4'(tail_cnt)] = want;
            tail_cnt++;
          end
          horner_acc = '0;
          error_flag = 1'b0;
        end
      end
    end
    mismatches     <= mismatch_cnt;
    hashes_pending <= tail_cnt - head_cnt;
  end

endmodule

[bench/tb_modular_polynomial_string_hash.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modular_polynomial_string_hash
// Feeds strings to the polynomial hash under several modulus and multiplier
// settings, with random gaps and output stalls; hash_checker does the scoring.
// ----------------------------------------------------------------------------
module tb_modular_polynomial_string_hash;
  import mphash_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 120;
  localparam int HOLD_CYCLES     = 600;
  localparam int CHARS_PER_PHASE = 150;
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG = '1;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_code = '0;
  logic        in_last_char = 1'b0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [31:0] out_hash_value;
  logic        out_bad_character;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data     = '0;

  int   mismatch_total;
  int   hashes_pending;
  int   cycle_count  = 0;
  int   chars_left   = 0;
  logic steady       = 1'b0;   // no gaps on either side
  logic hold_request = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  modular_polynomial_string_hash dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_code      (in_char_code),
    .in_last_char      (in_last_char),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hash_value    (out_hash_value),
    .out_bad_character (out_bad_character),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  hash_checker hash_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_code      (in_char_code),
    .in_last_char      (in_last_char),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hash_value    (out_hash_value),
    .out_bad_character (out_bad_character),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatches        (mismatch_total),
    .hashes_pending    (hashes_pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] random_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 8'($urandom);
    if (r < 18) return CH_SPACE;
    if (r < 60) return CH_LO_A + 8'($urandom_range(0, 25));
    return CH_UP_A + 8'($urandom_range(0, 25));
  endfunction

  function automatic int string_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 8);
    if (r < 97) return $urandom_range(9, 24);
    return $urandom_range(25, 60);
  endfunction

  // one character request; in_valid stays up if the next one follows at once
  task automatic drive_char(input logic [7:0] ch, input logic is_last);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= ch;
    in_last_char <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // strings may run across a phase boundary, so the new modulus applies mid-string
  task automatic drive_random_chars(input int count);
    for (int i = 0; i < count; i++) begin
      if (chars_left == 0) chars_left = string_length();
      drive_char(random_char(), chars_left == 1);
      chars_left--;
    end
  endtask

  // settle first: the pending count is registered and lags the last request
  task automatic wait_drained();
    in_valid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (hashes_pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_hash(input logic [31:0] m, input logic [15:0] w,
                              input logic poke_unused);
    wait_drained();
    if (poke_unused) write_reg(UNUSED_REG, $urandom);
    write_reg(CFG_MODULUS, m);
    // upper bits of the multiplier write are don't-care
    write_reg(CFG_MULTIPLIER, {16'($urandom), w});
    cfg_valid <= 1'b0;
  endtask

  // output side: random stalls, one long hold-off when asked
  initial begin : out_side
    int   span;
    logic hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (steady || $urandom_range(0, 99) < 65) begin
        out_stall <= 1'b0;
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 8);
        repeat (span) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        repeat (span) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting: modulus 31, multiplier 13
    drive_char("a", 1'b1);
    drive_char("Z", 1'b1);
    drive_char(CH_SPACE, 1'b1);
    drive_char("z", 1'b0);
    drive_char("A", 1'b1);
    // bad characters, including the neighbors of each letter range
    drive_char(8'h00, 1'b0);
    drive_char("b", 1'b1);
    drive_char(8'hFF, 1'b1);
    drive_char(8'h40, 1'b0);
    drive_char(8'h5B, 1'b0);
    drive_char(8'h60, 1'b0);
    drive_char(8'h7B, 1'b0);
    drive_char(8'h80, 1'b1);
    // modulus drops below the running value in the middle of a string
    drive_char("H", 1'b0);
    drive_char("e", 1'b0);
    program_hash(32'd7, 16'd3, 1'b0);
    drive_char("l", 1'b0);
    drive_char("l", 1'b0);
    drive_char("o", 1'b1);

    steady = 1'b1;
    program_hash(32'd0, 16'hFFFF, 1'b0);
    drive_random_chars(CHARS_PER_PHASE);
    steady = 1'b0;

    program_hash(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    drive_random_chars(CHARS_PER_PHASE);

    program_hash(32'd1, 16'd0, 1'b1);
    drive_random_chars(CHARS_PER_PHASE);

    program_hash(32'd2, 16'd1, 1'b0);
    drive_random_chars(CHARS_PER_PHASE);

    program_hash($urandom, 16'($urandom), 1'b0);
    drive_random_chars(CHARS_PER_PHASE);

    program_hash($urandom_range(2, 1000), 16'($urandom), 1'b0);
    hold_request = 1'b1;
    drive_random_chars(CHARS_PER_PHASE);
    hold_request = 1'b0;

    program_hash(32'h8000_0000, 16'($urandom), 1'b1);
    drive_random_chars(CHARS_PER_PHASE);

    program_hash(MODULUS_RESET, MULTIPLIER_RESET, 1'b0);
    drive_random_chars(CHARS_PER_PHASE);

    wait_drained();
    if (mismatch_total == 0 && hashes_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/mphash_pkg.sv
rtl/mphash_rem.sv
rtl/modular_polynomial_string_hash.sv
bench/hash_checker.sv
bench/tb_modular_polynomial_string_hash.sv
